/* hdl/gts_pkg.sv */
// ----------------------------------------------------------------------------
// gts_pkg
// Shared constants for the gated three-point smoother: sample width default,
// threshold format and the Q1.16 value of one.
// ----------------------------------------------------------------------------
`default_nettype none

package gts_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int THRESH_BITS         = 17;
   localparam int FRAC_BITS           = 16;

   localparam logic [THRESH_BITS-1:0] THRESH_ONE = THRESH_BITS'(65536);
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = '0;

endpackage

`default_nettype wire

/* hdl/gated_three_point_smoother.sv */
// ----------------------------------------------------------------------------
// gated_three_point_smoother
// Smooths a signed sample stream over three history slots, gated by a
// relative tolerance against the newest filled slot.
//
// Channels: req_ carries one sample per beat, rsp_ returns one smoothed
// value per beat, in order. csr_ writes the Q1.16 match threshold; values
// above 1.0 saturate. Write it only while no beat is in flight.
// A taken req_ beat passes through the input register, then the result
// register, which drives rsp_valid. Throughput: one beat per cycle while
// rsp_ready is high; the slot update completes in the single step between
// the two registers, so the next sample sees it at once.
// Reset: slots go to -1 (empty), threshold to zero, both registers empty.
// Stall: while rsp_ready is low the result register holds its beat and the
// input register still takes one more sample; req_ready then drops until
// the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module gated_three_point_smoother #(
   parameter int SAMPLE_BITS = gts_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]            rsp_smoothed_value,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [gts_pkg::THRESH_BITS-1:0]     csr_match_threshold
);

   localparam int SUM_BITS  = SAMPLE_BITS + 2;
   localparam int PAIR_BITS = SAMPLE_BITS + 1;
   localparam logic signed [SAMPLE_BITS-1:0] EMPTY = '1;

   logic                              in_valid_ff, in_valid_in;
   logic signed [SAMPLE_BITS-1:0]     sample_ff, sample_in;
   logic                              out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0]     out_value_ff, out_value_in;
   logic signed [SAMPLE_BITS-1:0]     oldest_ff, oldest_in;
   logic signed [SAMPLE_BITS-1:0]     middle_ff, middle_in;
   logic signed [SAMPLE_BITS-1:0]     newest_ff, newest_in;
   logic [gts_pkg::THRESH_BITS-1:0]   threshold_ff, threshold_in;

   logic                              advance;
   logic                              newest_full, middle_full, oldest_full;
   logic signed [SAMPLE_BITS-1:0]     ref_value;
   logic                              in_range;
   logic signed [SUM_BITS-1:0]        sum3;
   logic signed [SUM_BITS-1:0]        mean3_wide;
   logic signed [SAMPLE_BITS-1:0]     mean3;
   logic signed [PAIR_BITS-1:0]       sum2;
   logic signed [PAIR_BITS-1:0]       sum2_adj;
   logic signed [SAMPLE_BITS-1:0]     mean2;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_smoothed_value = out_value_ff;

   assign newest_full = !newest_ff[SAMPLE_BITS-1] && (newest_ff != '0);
   assign middle_full = !middle_ff[SAMPLE_BITS-1] && (middle_ff != '0);
   assign oldest_full = !oldest_ff[SAMPLE_BITS-1] && (oldest_ff != '0);

   always_comb begin
      if (newest_full) begin
         ref_value = newest_ff;
      end else if (middle_full) begin
         ref_value = middle_ff;
      end else begin
         ref_value = oldest_ff;
      end
   end

   gts_tolerance #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_tolerance (
      .ref_value (ref_value),
      .sample    (sample_ff),
      .threshold (threshold_ff),
      .in_range  (in_range)
   );

   always_comb begin
      sum3 = SUM_BITS'(middle_ff) + SUM_BITS'(sample_ff)
           + (newest_full ? SUM_BITS'(newest_ff) : SUM_BITS'(oldest_ff));
   end

   gts_div3 #(
      .SUM_BITS (SUM_BITS)
   ) u_div3 (
      .dividend (sum3),
      .quotient (mean3_wide)
   );

   always_comb begin
      mean3    = mean3_wide[SAMPLE_BITS-1:0];
      sum2     = PAIR_BITS'(oldest_ff) + PAIR_BITS'(sample_ff);
      sum2_adj = sum2 + PAIR_BITS'(sum2[PAIR_BITS-1]);
      mean2    = sum2_adj[PAIR_BITS-1:1];
   end

   always_comb begin
      oldest_in    = oldest_ff;
      middle_in    = middle_ff;
      newest_in    = newest_ff;
      out_value_in = sample_ff;
      if (advance) begin
         if (newest_full || middle_full || oldest_full) begin
            if (!in_range) begin
               oldest_in = EMPTY;
               middle_in = EMPTY;
               newest_in = EMPTY;
            end else if (newest_full) begin
               out_value_in = mean3;
               oldest_in    = middle_ff;
               middle_in    = newest_ff;
               newest_in    = mean3;
            end else if (middle_full) begin
               out_value_in = mean3;
               newest_in    = mean3;
            end else begin
               out_value_in = mean2;
               middle_in    = mean2;
            end
         end else begin
            oldest_in = sample_ff;
         end
      end
   end

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      sample_in = (req_valid && req_ready) ? req_sample : sample_ff;

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      if (csr_valid) begin
         threshold_in = (csr_match_threshold > gts_pkg::THRESH_ONE)
                      ? gts_pkg::THRESH_ONE : csr_match_threshold;
      end else begin
         threshold_in = threshold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         oldest_ff    <= EMPTY;
         middle_ff    <= EMPTY;
         newest_ff    <= EMPTY;
         threshold_ff <= gts_pkg::THRESH_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         oldest_ff    <= oldest_in;
         middle_ff    <= middle_in;
         newest_ff    <= newest_in;
         threshold_ff <= threshold_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      if (advance) begin
         out_value_ff <= out_value_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/gts_div3.sv */
// ----------------------------------------------------------------------------
// gts_div3
// Signed divide by three, truncated toward zero. Reciprocal multiply on the
// magnitude, then a single compare-and-correct step.
// ----------------------------------------------------------------------------
`default_nettype none

module gts_div3 #(
   parameter int SUM_BITS = 18
) (
   input  wire logic signed [SUM_BITS-1:0] dividend,
   output logic signed [SUM_BITS-1:0]      quotient
);

   localparam logic [SUM_BITS:0]   POW   = {1'b1, {SUM_BITS{1'b0}}};
   localparam logic [SUM_BITS-1:0] RECIP = SUM_BITS'(POW / 3);
   localparam logic [SUM_BITS-1:0] THREE = SUM_BITS'(3);

   logic                    negative;
   logic [SUM_BITS-1:0]     magnitude;
   logic [2*SUM_BITS-1:0]   product;
   logic [SUM_BITS-1:0]     q_est;
   logic [SUM_BITS-1:0]     remainder;
   logic [SUM_BITS-1:0]     q_abs;

   always_comb begin
      negative  = dividend[SUM_BITS-1];
      magnitude = negative ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
      product   = (2*SUM_BITS)'(magnitude) * (2*SUM_BITS)'(RECIP);
      q_est     = product[2*SUM_BITS-1:SUM_BITS];
      remainder = magnitude - (SUM_BITS'({q_est, 1'b0}) + q_est);
      q_abs     = (remainder >= THREE) ? q_est + SUM_BITS'(1) : q_est;
      quotient  = negative ? $signed(-q_abs) : $signed(q_abs);
   end

endmodule

`default_nettype wire

/* hdl/gts_tolerance.sv */
// ----------------------------------------------------------------------------
// gts_tolerance
// Relative tolerance test: |ref - sample| * 1.0 < ref * threshold, exact,
// with the threshold in Q1.16.
// ----------------------------------------------------------------------------
`default_nettype none

module gts_tolerance #(
   parameter int SAMPLE_BITS = gts_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic signed [SAMPLE_BITS-1:0]        ref_value,
   input  wire logic signed [SAMPLE_BITS-1:0]        sample,
   input  wire logic [gts_pkg::THRESH_BITS-1:0]      threshold,
   output logic                                      in_range
);

   localparam int DIFF_BITS = SAMPLE_BITS + 1;
   localparam int CMP_BITS  = SAMPLE_BITS + gts_pkg::THRESH_BITS;

   logic signed [DIFF_BITS-1:0] diff;
   logic [DIFF_BITS-1:0]        abs_diff;
   logic [CMP_BITS-1:0]         lhs;
   logic [CMP_BITS-1:0]         rhs;

   always_comb begin
      diff     = $signed({ref_value[SAMPLE_BITS-1], ref_value})
               - $signed({sample[SAMPLE_BITS-1], sample});
      abs_diff = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
      lhs      = CMP_BITS'(abs_diff) << gts_pkg::FRAC_BITS;
      rhs      = CMP_BITS'($unsigned(ref_value)) * CMP_BITS'(threshold);
      in_range = lhs < rhs;
   end

endmodule

`default_nettype wire
